@@ hdl/young_tableau_priority_queue_defines.svh @@
// Assertion macros for the young tableau priority queue.
// Used by modules that sample clk and rst in their own scope.
`ifndef YOUNG_TABLEAU_PRIORITY_QUEUE_DEFINES_SVH
`define YOUNG_TABLEAU_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, off during reset
`define YT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("young tableau check failed");

// next-cycle implication, off during reset
`define YT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("young tableau check failed");

`endif

@@ hdl/yt_pkg.sv @@
// Shared constants, codes and control structs of the young tableau queue.
// No dependencies.
package yt_pkg;

  // port field widths
  localparam int CMD_W     = 3;
  localparam int KEY_W     = 16;
  localparam int POS_W     = 4;
  localparam int STAT_W    = 2;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  // default sizes
  localparam int DEF_MAX_ROWS = 8;
  localparam int DEF_MAX_COLS = 8;
  localparam int DEF_KEY_BITS = 16;

  // commands
  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EXTRACT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FIND     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DECREASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

  // configuration registers
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;
  localparam logic [CFG_W-1:0]     ROWS_RESET = 4'd8;
  localparam logic [CFG_W-1:0]     COLS_RESET = 4'd8;

  // neighbor control into the compare unit
  typedef struct packed {
    logic up;     // sift toward top-left, else toward bottom-right
    logic a_ok;   // north/south neighbor exists
    logic b_ok;   // west/east neighbor exists
  } yt_nbr_t;

  // compare unit verdict
  typedef struct packed {
    logic move;    // a neighbor beats the moving key
    logic take_b;  // the west/east neighbor wins
    logic a_eq;    // first read word equals the key
    logic a_lt;    // first read word is below the key
  } yt_step_t;

endpackage

@@ hdl/yt_if.sv @@
// Valid/ready channel interfaces for the young tableau queue.
// Depends on yt_pkg.
interface yt_req_if;
  import yt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [KEY_W-1:0]     key;
  logic [POS_W-1:0]     row;
  logic [POS_W-1:0]     col;
  modport source (output valid, command, key, row, col, input ready);
  modport sink   (input valid, command, key, row, col, output ready);
endinterface

interface yt_rsp_if;
  import yt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [KEY_W-1:0]     value_out;
  logic                 found;
  logic [KEY_W-1:0]     current_min;
  modport source (output valid, status, value_out, found, current_min, input ready);
  modport sink   (input valid, status, value_out, found, current_min, output ready);
endinterface

@@ hdl/yt_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module yt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [WIDTH-1:0]  rdata0,
  output logic [WIDTH-1:0]  rdata1
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end
endmodule

@@ hdl/yt_cells.sv @@
// Tableau cell store: RAM plus per-cell written flags; unwritten cells read empty.
// Depends on yt_ram.
module yt_cells #(
  parameter int KEY_BITS = 16,
  parameter int DEPTH    = 64,
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [KEY_BITS-1:0] wdata,
  input  logic [ADDR_W-1:0]   raddr0,
  input  logic [ADDR_W-1:0]   raddr1,
  output logic [KEY_BITS-1:0] rdata0,
  output logic [KEY_BITS-1:0] rdata1
);
  localparam logic [KEY_BITS-1:0] EMPTY = '1;

  logic [DEPTH-1:0]    written;
  logic                hit0;
  logic                hit1;
  logic [KEY_BITS-1:0] ram0;
  logic [KEY_BITS-1:0] ram1;

  yt_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (ram0),
    .rdata1 (ram1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      hit0    <= 1'b0;
      hit1    <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      hit0 <= written[raddr0];
      hit1 <= written[raddr1];
    end
  end

  assign rdata0 = hit0 ? ram0 : EMPTY;
  assign rdata1 = hit1 ? ram1 : EMPTY;
endmodule

@@ hdl/yt_step.sv @@
// Shared compare unit: picks the winning neighbor of a sift step and
// compares the first read word against the key for probes and the search.
// Depends on yt_pkg.
module yt_step #(
  parameter int KEY_BITS = 16
) (
  input  logic [KEY_BITS-1:0] k,
  input  logic [KEY_BITS-1:0] da,
  input  logic [KEY_BITS-1:0] db,
  input  yt_pkg::yt_nbr_t     nbr,
  output yt_pkg::yt_step_t    res,
  output logic [KEY_BITS-1:0] win
);
  import yt_pkg::*;

  logic                a_win;
  logic                b_win;
  logic [KEY_BITS-1:0] best;

  always_comb begin
    // up: larger neighbor wins; down: smaller one; ties keep north/south
    a_win = nbr.a_ok && (nbr.up ? (da > k) : (da < k));
    best  = a_win ? da : k;
    b_win = nbr.b_ok && (nbr.up ? (db > best) : (db < best));
    res.move   = a_win || b_win;
    res.take_b = b_win;
    res.a_eq   = (da == k);
    res.a_lt   = (da < k);
    win        = b_win ? db : da;
  end
endmodule

@@ hdl/young_tableau_priority_queue.sv @@
// Young tableau priority queue, top level: sequencer, size registers, result register.
// Each sift step and each search probe is a cell-RAM read, then a compare.
// Ready only while idle, so a new word is taken only once the last is done; a held result stalls the next.
// Synchronous reset empties the grid (written flags) and sets the size to 8x8.
`include "young_tableau_priority_queue_defines.svh"

module young_tableau_priority_queue #(
  parameter int MAX_ROWS = yt_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = yt_pkg::DEF_MAX_COLS,
  parameter int KEY_BITS = yt_pkg::DEF_KEY_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  yt_req_if.sink                      req,
  yt_rsp_if.source                    rsp,
  input  logic                        cfg_we,
  input  logic [yt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [yt_pkg::CFG_W-1:0]    cfg_data
);
  import yt_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [KEY_BITS-1:0] EMPTY = '1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_PRB_RD   = 4'd2;
  localparam logic [3:0] S_PRB_CHK  = 4'd3;
  localparam logic [3:0] S_SIFT_RD  = 4'd4;
  localparam logic [3:0] S_SIFT_CMP = 4'd5;
  localparam logic [3:0] S_FIND_RD  = 4'd6;
  localparam logic [3:0] S_FIND_CHK = 4'd7;
  localparam logic [3:0] S_MIN      = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] rr,
                                                  input logic [POS_W-1:0] cc);
    return ADDR_W'(int'(rr) * MAX_COLS + int'(cc));
  endfunction

  logic [3:0]          state;
  logic [CFG_W-1:0]    rows_in_use;
  logic [CFG_W-1:0]    cols_in_use;
  logic [CMD_W-1:0]    op;
  logic [KEY_BITS-1:0] k;
  logic [POS_W-1:0]    trow;
  logic [POS_W-1:0]    tcol;
  logic [POS_W-1:0]    r;
  logic [POS_W-1:0]    c;
  logic                up;
  logic [STAT_W-1:0]   status_q;
  logic [KEY_BITS-1:0] value_q;
  logic                found_q;

  logic                rsp_valid;
  logic [STAT_W-1:0]   rsp_status;
  logic [KEY_W-1:0]    rsp_value;
  logic                rsp_found;
  logic [KEY_W-1:0]    rsp_min;
  logic                load_rsp;

  logic [POS_W-1:0]    h;
  logic [POS_W-1:0]    w;
  logic                pos_ok;
  logic [POS_W-1:0]    na_r;
  logic [POS_W-1:0]    nb_c;
  logic                a_ok;
  logic                b_ok;
  yt_nbr_t             nbr;
  yt_step_t            st;
  logic [KEY_BITS-1:0] win;

  logic                wr_en;
  logic [ADDR_W-1:0]   waddr;
  logic [KEY_BITS-1:0] wdata;
  logic [ADDR_W-1:0]   raddr0;
  logic [ADDR_W-1:0]   raddr1;
  logic [KEY_BITS-1:0] d0;
  logic [KEY_BITS-1:0] d1;

  // sizes in use: zero or oversize falls back to the full grid
  assign h = (rows_in_use == '0 || int'(rows_in_use) > MAX_ROWS) ?
             POS_W'(MAX_ROWS) : POS_W'(rows_in_use);
  assign w = (cols_in_use == '0 || int'(cols_in_use) > MAX_COLS) ?
             POS_W'(MAX_COLS) : POS_W'(cols_in_use);
  assign pos_ok = (trow != '0) && (trow <= h) && (tcol != '0) && (tcol <= w);

  assign na_r = up ? (r - POS_W'(1)) : (r + POS_W'(1));
  assign nb_c = up ? (c - POS_W'(1)) : (c + POS_W'(1));
  assign a_ok = up ? (r != '0) : (({1'b0, r} + (POS_W+1)'(1)) < {1'b0, h});
  assign b_ok = up ? (c != '0) : (({1'b0, c} + (POS_W+1)'(1)) < {1'b0, w});
  assign nbr  = '{up: up, a_ok: a_ok, b_ok: b_ok};

  // result register takes a new word when it is empty or being drained
  assign load_rsp = (state == S_DONE) && (!rsp_valid || rsp.ready);

  yt_cells #(.KEY_BITS(KEY_BITS), .DEPTH(DEPTH)) u_cells (
    .clk    (clk),
    .rst    (rst),
    .we     (wr_en),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (d0),
    .rdata1 (d1)
  );

  yt_step #(.KEY_BITS(KEY_BITS)) u_step (
    .k   (k),
    .da  (d0),
    .db  (d1),
    .nbr (nbr),
    .res (st),
    .win (win)
  );

  // cell addresses; port 0 idles on the top-left cell for the minimum readout
  always_comb begin
    raddr0 = '0;
    raddr1 = '0;
    wr_en  = 1'b0;
    waddr  = cell_addr(r, c);
    wdata  = k;
    case (state)
      S_PRB_RD: begin
        raddr0 = cell_addr(r, c);
      end
      S_SIFT_RD: begin
        raddr0 = a_ok ? cell_addr(na_r, c) : cell_addr(r, c);
        raddr1 = b_ok ? cell_addr(r, nb_c) : cell_addr(r, c);
      end
      S_SIFT_CMP: begin
        // pull the winner into the hole, or drop the moving key here
        wr_en = 1'b1;
        wdata = st.move ? win : k;
      end
      S_FIND_RD: begin
        raddr0 = cell_addr(r - POS_W'(1), c);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS: rows_in_use <= cfg_data;
          REG_COLS: cols_in_use <= cfg_data;
          default: ;
        endcase
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.command;
            k     <= KEY_BITS'(req.key);
            trow  <= req.row;
            tcol  <= req.col;
            state <= S_START;
          end
        end
        S_START: begin
          status_q <= ST_OK;
          value_q  <= '0;
          found_q  <= 1'b0;
          case (op)
            CMD_INSERT: begin
              r     <= h - POS_W'(1);
              c     <= w - POS_W'(1);
              up    <= 1'b1;
              state <= S_PRB_RD;
            end
            CMD_EXTRACT: begin
              r     <= '0;
              c     <= '0;
              up    <= 1'b0;
              state <= S_PRB_RD;
            end
            CMD_FIND: begin
              // r runs one above the row being looked at
              r     <= h;
              c     <= '0;
              state <= S_FIND_RD;
            end
            CMD_DECREASE, CMD_DELETE: begin
              if (!pos_ok) begin
                status_q <= ST_RANGE;
                state    <= S_MIN;
              end else begin
                r     <= trow - POS_W'(1);
                c     <= tcol - POS_W'(1);
                up    <= (op == CMD_DECREASE);
                state <= S_PRB_RD;
              end
            end
            default: begin
              status_q <= ST_BAD;
              state    <= S_MIN;
            end
          endcase
        end
        S_PRB_RD: begin
          state <= S_PRB_CHK;
        end
        S_PRB_CHK: begin
          case (op)
            CMD_INSERT: begin
              if (d0 != EMPTY) begin
                status_q <= ST_FULL;
                state    <= S_MIN;
              end else begin
                state <= S_SIFT_RD;
              end
            end
            CMD_EXTRACT: begin
              value_q <= d0;
              k       <= EMPTY;
              state   <= S_SIFT_RD;
            end
            CMD_DECREASE: begin
              if (st.a_lt) begin
                status_q <= ST_BAD;
                state    <= S_MIN;
              end else begin
                state <= S_SIFT_RD;
              end
            end
            CMD_DELETE: begin
              if (d0 == EMPTY) begin
                status_q <= ST_BAD;
                state    <= S_MIN;
              end else begin
                k     <= EMPTY;
                state <= S_SIFT_RD;
              end
            end
            default: begin
              state <= S_MIN;
            end
          endcase
        end
        S_SIFT_RD: begin
          state <= S_SIFT_CMP;
        end
        S_SIFT_CMP: begin
          if (st.move) begin
            if (st.take_b) begin
              c <= nb_c;
            end else begin
              r <= na_r;
            end
            state <= S_SIFT_RD;
          end else begin
            state <= S_MIN;
          end
        end
        S_FIND_RD: begin
          state <= S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (st.a_eq) begin
            found_q <= 1'b1;
            state   <= S_MIN;
          end else if (st.a_lt) begin
            // advance right
            c     <= c + POS_W'(1);
            state <= (({1'b0, c} + (POS_W+1)'(1)) < {1'b0, w}) ? S_FIND_RD : S_MIN;
          end else begin
            // advance up
            r     <= r - POS_W'(1);
            state <= (r > POS_W'(1)) ? S_FIND_RD : S_MIN;
          end
        end
        S_MIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the result register is free
          if (load_rsp) begin
            rsp_status <= status_q;
            rsp_value  <= KEY_W'(value_q);
            rsp_found  <= found_q;
            rsp_min    <= KEY_W'(d0);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.value_out   = rsp_value;
  assign rsp.found       = rsp_found;
  assign rsp.current_min = rsp_min;

  `YT_ASSERT_NOW(a_idle_no_write, state == S_IDLE, !wr_en)
  `YT_ASSERT_NEXT(a_load_from_done, load_rsp, rsp.valid && req.ready)
  `YT_ASSERT_NOW(a_extract_ok, state == S_DONE && op == CMD_EXTRACT, status_q == ST_OK)
  `YT_ASSERT_NOW(a_full_only_insert, state == S_DONE && status_q == ST_FULL, op == CMD_INSERT)
  `YT_ASSERT_NOW(a_found_only_find, state == S_DONE && found_q, op == CMD_FIND)
endmodule
